[rtl/core/crsc_pkg.sv]
// Shared constants and types for the column-to-row span converter.
// No dependencies.
`default_nettype none

package crsc_pkg;

   localparam int ROWS  = 64;
   localparam int ROW_W = 6;    // row index
   localparam int TOP_W = 7;    // row index or ROWS (empty)
   localparam int COL_W = 10;   // screen column

   localparam logic [TOP_W-1:0] TOP_EMPTY = TOP_W'(ROWS);

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] start;
      logic [COL_W-1:0] stop;
   } span_type;

endpackage

`default_nettype wire

[rtl/core/column_to_row_span_converter_unit.sv]
// Column-to-row span converter, top level: sequencer, span buffer, output register.
// Depends on crsc_pkg and crsc_ram.
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  req_    | in        | req_valid/req_stall  | column_x, top_row, bottom_row, first/last
//  rsp_    | out       | rsp_valid/rsp_stall  | span_row, span_start, span_end, span_final
//
//  Per column: accept in S_IDLE, then a pass through S_CTOP, S_CBOT, S_OTOP and
//  S_OBOT, then S_FLUSH; last_column adds a second pass. Each closed row also takes
//  S_CREAD, the registered read of the start-column RAM.
//  Reset clears the sequencer, the previous extent (empty) and both output slots;
//  the start-column RAM is not cleared. req_stall is high from accept until flush.
//  A full output stage with rsp_stall high holds the sequencer at the next span.

module column_to_row_span_converter_unit
   import crsc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [COL_W-1:0] req_column_x,
   input  wire logic [TOP_W-1:0] req_top_row,
   input  wire logic [ROW_W-1:0] req_bottom_row,
   input  wire logic             req_first_column,
   input  wire logic             req_last_column,

   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [ROW_W-1:0] rsp_span_row,
   output logic      [COL_W-1:0] rsp_span_start,
   output logic      [COL_W-1:0] rsp_span_end,
   output logic                  rsp_span_final
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CTOP,    // close rows above the new top, walking down
      S_CBOT,    // close rows below the new bottom, walking up
      S_CREAD,   // start column arrives from RAM
      S_OTOP,    // open newly covered upper rows
      S_OBOT,    // open newly covered lower rows
      S_FLUSH    // last held span goes out marked final
   } state_type;

   state_type        state_ff, state_in, ret_ff, ret_in;
   logic [TOP_W-1:0] t1_ff, t1_in, b1_ff, b1_in, t2_ff, t2_in, b2_ff, b2_in;
   logic [TOP_W-1:0] top_ff, top_in, bot_ff, bot_in;
   logic [TOP_W-1:0] prev_top_ff, prev_top_in;
   logic [ROW_W-1:0] prev_bot_ff, prev_bot_in;
   logic [COL_W-1:0] x_ff, x_in;
   logic             last_ff, last_in, pass_ff, pass_in;
   logic [ROW_W-1:0] fetch_row_ff, fetch_row_in;
   logic             held_valid_ff, held_valid_in;
   span_type         held_ff, held_in;
   logic             out_valid_ff, out_valid_in;
   span_type         out_ff, out_in;
   logic             out_final_ff, out_final_in;

   // RAM port
   logic             wr_en, rd_en;
   logic [ROW_W-1:0] wr_addr, rd_addr;
   logic [COL_W-1:0] rd_data;

   // current step's column and the end column of spans closed by it
   logic [COL_W-1:0] col, end_col;
   logic             out_free;
   logic [TOP_W-1:0] top_clamped;

   assign col         = x_ff + COL_W'(pass_ff);
   assign end_col     = col - COL_W'(1);
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign top_clamped = (req_top_row > TOP_EMPTY) ? TOP_EMPTY : req_top_row;

   crsc_ram #(
      .WIDTH (COL_W),
      .DEPTH (ROWS)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (col),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      t1_in         = t1_ff;
      b1_in         = b1_ff;
      t2_in         = t2_ff;
      b2_in         = b2_ff;
      top_in        = top_ff;
      bot_in        = bot_ff;
      prev_top_in   = prev_top_ff;
      prev_bot_in   = prev_bot_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      pass_in       = pass_ff;
      fetch_row_in  = fetch_row_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      out_in        = out_ff;
      out_final_in  = out_final_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      wr_en         = 1'b0;
      wr_addr       = t2_ff[ROW_W-1:0];
      rd_en         = 1'b0;
      rd_addr       = t1_ff[ROW_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in    = req_column_x;
               last_in = req_last_column;
               pass_in = 1'b0;
               top_in  = top_clamped;
               bot_in  = {1'b0, req_bottom_row};
               t2_in   = top_clamped;
               b2_in   = {1'b0, req_bottom_row};
               if (req_first_column) begin
                  t1_in = TOP_EMPTY;
                  b1_in = '0;
               end else begin
                  t1_in = prev_top_ff;
                  b1_in = {1'b0, prev_bot_ff};
               end
               state_in = S_CTOP;
            end
         end
         S_CTOP: begin
            if (t1_ff < t2_ff && t1_ff <= b1_ff) begin
               if (!held_valid_ff || out_free) begin
                  if (held_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in       = held_ff;
                     out_final_in = 1'b0;
                  end
                  rd_en        = 1'b1;
                  rd_addr      = t1_ff[ROW_W-1:0];
                  fetch_row_in = t1_ff[ROW_W-1:0];
                  t1_in        = t1_ff + TOP_W'(1);
                  ret_in       = S_CTOP;
                  state_in     = S_CREAD;
               end
            end else begin
               state_in = S_CBOT;
            end
         end
         S_CBOT: begin
            if (b1_ff > b2_ff && b1_ff >= t1_ff) begin
               if (!held_valid_ff || out_free) begin
                  if (held_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in       = held_ff;
                     out_final_in = 1'b0;
                  end
                  rd_en        = 1'b1;
                  rd_addr      = b1_ff[ROW_W-1:0];
                  fetch_row_in = b1_ff[ROW_W-1:0];
                  b1_in        = b1_ff - TOP_W'(1);
                  ret_in       = S_CBOT;
                  state_in     = S_CREAD;
               end
            end else begin
               state_in = S_OTOP;
            end
         end
         S_CREAD: begin
            held_valid_in = 1'b1;
            held_in.row   = fetch_row_ff;
            held_in.start = rd_data;
            held_in.stop  = end_col;
            state_in      = ret_ff;
         end
         S_OTOP: begin
            if (t2_ff < t1_ff && t2_ff <= b2_ff) begin
               wr_en   = 1'b1;
               wr_addr = t2_ff[ROW_W-1:0];
               t2_in   = t2_ff + TOP_W'(1);
            end else begin
               state_in = S_OBOT;
            end
         end
         S_OBOT: begin
            if (b2_ff > b1_ff && b2_ff >= t2_ff) begin
               wr_en   = 1'b1;
               wr_addr = b2_ff[ROW_W-1:0];
               b2_in   = b2_ff - TOP_W'(1);
            end else if (last_ff && !pass_ff) begin
               // closing pass: an empty column one to the right
               pass_in  = 1'b1;
               t1_in    = top_ff;
               b1_in    = bot_ff;
               t2_in    = TOP_EMPTY;
               b2_in    = '0;
               state_in = S_CTOP;
            end else begin
               if (last_ff) begin
                  prev_top_in = TOP_EMPTY;
                  prev_bot_in = '0;
               end else begin
                  prev_top_in = top_ff;
                  prev_bot_in = bot_ff[ROW_W-1:0];
               end
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!held_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = held_ff;
               out_final_in  = 1'b1;
               held_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_CTOP;
         prev_top_ff   <= TOP_EMPTY;
         prev_bot_ff   <= '0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         prev_top_ff   <= prev_top_in;
         prev_bot_ff   <= prev_bot_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      t1_ff        <= t1_in;
      b1_ff        <= b1_in;
      t2_ff        <= t2_in;
      b2_ff        <= b2_in;
      top_ff       <= top_in;
      bot_ff       <= bot_in;
      x_ff         <= x_in;
      last_ff      <= last_in;
      pass_ff      <= pass_in;
      fetch_row_ff <= fetch_row_in;
      held_ff      <= held_in;
      out_ff       <= out_in;
      out_final_ff <= out_final_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = out_valid_ff;
   assign rsp_span_row   = out_ff.row;
   assign rsp_span_start = out_ff.start;
   assign rsp_span_end   = out_ff.stop;
   assign rsp_span_final = out_final_ff;

endmodule

`default_nettype wire

[rtl/core/crsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module crsc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[dv/column_to_row_span_converter_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench for column_to_row_span_converter_unit: sends column extents, predicts the row
// spans they close and checks every result beat in order. Depends on crsc_pkg and the RTL.

module column_to_row_span_converter_unit_tb;
   import crsc_pkg::*;

   // Worst case per column is every row closing, each result beat behind the longest
   // stall, plus the longest send gap; ~300 columns of that fit well inside.
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 500;   // watch for stray beats after the drain
   localparam int MAX_WAIT      = 11;

   // One expected result beat: the span plus the flag that marks the column's last span.
   typedef struct packed {
      span_type span;
      logic     closes_column;
   } span_beat_type;

   logic             clock;
   logic             reset;

   logic             req_valid;
   logic             req_stall;
   logic [COL_W-1:0] req_column_x;
   logic [TOP_W-1:0] req_top_row;
   logic [ROW_W-1:0] req_bottom_row;
   logic             req_first_column;
   logic             req_last_column;

   logic             rsp_valid;
   logic             rsp_stall;
   logic [ROW_W-1:0] rsp_span_row;
   logic [COL_W-1:0] rsp_span_start;
   logic [COL_W-1:0] rsp_span_end;
   logic             rsp_span_final;

   // Predictor state: start column per open row, and the previous column's extent.
   logic [COL_W:0]   row_open_column [ROWS];
   int               last_top    = ROWS;
   int               last_bottom = 0;

   span_beat_type    expected_spans[$];

   int               columns_sent   = 0;
   int               spans_checked  = 0;
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   bit               no_idle        = 1'b0;

   column_to_row_span_converter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_column_x     (req_column_x),
      .req_top_row      (req_top_row),
      .req_bottom_row   (req_bottom_row),
      .req_first_column (req_first_column),
      .req_last_column  (req_last_column),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_span_row     (rsp_span_row),
      .rsp_span_start   (rsp_span_start),
      .rsp_span_end     (rsp_span_end),
      .rsp_span_final   (rsp_span_final)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timed out, %0d spans still outstanding", $time, expected_spans.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Per-beat wait for either side; zero everywhere while the back-to-back test runs.
   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // One step from extent (t1,b1) to extent (t2,b2) at column x. Rows leaving coverage
   // close at x-1: upper ones walking down from the old top, then lower ones walking up
   // from the old bottom. Rows entering coverage take x as their start column.
   function automatic void advance_extent(input logic [COL_W:0] x, input int t1, input int b1,
                                          input int t2, input int b2);
      span_beat_type beat;
      beat.closes_column = 1'b0;
      beat.span.stop     = COL_W'(x - 1'b1);   // x of zero wraps to the top column
      while (t1 < t2 && t1 <= b1) begin
         beat.span.row   = ROW_W'(t1);
         beat.span.start = row_open_column[t1][COL_W-1:0];
         expected_spans.push_back(beat);
         t1++;
      end
      while (b1 > b2 && b1 >= t1) begin
         beat.span.row   = ROW_W'(b1);
         beat.span.start = row_open_column[b1][COL_W-1:0];
         expected_spans.push_back(beat);
         b1--;
      end
      while (t2 < t1 && t2 <= b2) begin
         row_open_column[t2] = x;
         t2++;
      end
      while (b2 > b1 && b2 >= t2) begin
         row_open_column[b2] = x;
         b2--;
      end
   endfunction

   // Expected spans for one accepted column beat, appended to expected_spans.
   function automatic void predict_spans(input logic [COL_W-1:0] x, input logic [TOP_W-1:0] top_in,
                                         input logic [ROW_W-1:0] bottom_in, input logic first,
                                         input logic last);
      int            top;
      int            bottom;
      int            base;
      span_beat_type tail;
      // a top past the empty code is still empty; a 6-bit bottom is always in range
      top    = (top_in > TOP_EMPTY) ? ROWS : int'(top_in);
      bottom = int'(bottom_in);
      base   = expected_spans.size();
      advance_extent({1'b0, x}, first ? ROWS : last_top, first ? 0 : last_bottom, top, bottom);
      if (last) begin
         // an empty column one past this one closes whatever is still open
         advance_extent({1'b0, x} + 1'b1, top, bottom, ROWS, 0);
         last_top    = ROWS;
         last_bottom = 0;
      end else begin
         last_top    = top;
         last_bottom = bottom;
      end
      if (expected_spans.size() > base) begin
         tail = expected_spans.pop_back();
         tail.closes_column = 1'b1;
         expected_spans.push_back(tail);
      end
   endfunction

   // Sender: optional idle gap, then hold the beat until the block takes it.
   task automatic send_column(input logic [COL_W-1:0] x, input logic [TOP_W-1:0] top,
                              input logic [ROW_W-1:0] bottom, input logic first,
                              input logic last);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_column_x     <= x;
      req_top_row      <= top;
      req_bottom_row   <= bottom;
      req_first_column <= first;
      req_last_column  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_spans(x, top, bottom, first, last);
      columns_sent++;
   endtask

   // Stop sending and wait until every predicted span has come back.
   task automatic drain_expected();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_spans.size() != 0) @(posedge clock);
   endtask

   // One well-formed plane: consecutive columns, first flag on the first, last flag on
   // the last, extents drifting a few rows at a time with empties and jumps mixed in.
   task automatic send_plane(input int width);
      logic [COL_W-1:0] x;
      int               top;
      int               bottom;
      int               pick;
      x      = COL_W'($urandom_range(0, 1023));
      top    = $urandom_range(0, 63);
      bottom = $urandom_range(top, 63);
      for (int i = 0; i < width; i++) begin
         if (i > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               top    = top + int'($urandom_range(0, 6)) - 3;
               bottom = bottom + int'($urandom_range(0, 6)) - 3;
               if (top < 0) top = 0;
               if (top > 63) top = 63;
               if (bottom < 0) bottom = 0;
               if (bottom > 63) bottom = 63;
            end else if (pick < 65) begin
               case ($urandom_range(0, 2))
                  0: top = ROWS;
                  1: top = $urandom_range(ROWS + 1, 127);
                  default: begin
                     top    = $urandom_range(1, 63);
                     bottom = $urandom_range(0, top - 1);
                  end
               endcase
            end else if (pick < 85) begin
               top    = $urandom_range(0, 63);
               bottom = $urandom_range(top, 63);
            end
         end
         send_column(x, TOP_W'(top), ROW_W'(bottom), i == 0, i == width - 1);
         x = x + 1'b1;
      end
   endtask

   // Edges of every field and each corner of the row walk.
   task automatic test_directed();
      send_column(10'd0,    7'd0,   6'd63, 1'b1, 1'b0);   // full column opens every row
      send_column(10'd1,    7'd0,   6'd63, 1'b0, 1'b0);   // unchanged, no spans
      send_column(10'd2,    7'd127, 6'd63, 1'b0, 1'b0);   // top past range: all 64 rows close
      send_column(10'd3,    7'd65,  6'd0,  1'b0, 1'b0);   // empty after empty
      send_column(10'd4,    TOP_EMPTY, 6'd0, 1'b0, 1'b0);
      send_column(10'd5,    7'd10,  6'd20, 1'b0, 1'b0);
      send_column(10'd6,    7'd5,   6'd25, 1'b0, 1'b0);   // grows both ways
      send_column(10'd7,    7'd12,  6'd18, 1'b0, 1'b0);   // shrinks: upper then lower closes
      send_column(10'd8,    7'd30,  6'd10, 1'b0, 1'b0);   // top above bottom: empty
      send_column(10'd1023, 7'd40,  6'd40, 1'b0, 1'b0);   // single row at the top column
      send_column(10'd0,    7'd41,  6'd41, 1'b0, 1'b0);   // close at column zero wraps
      send_column(10'd1,    7'd41,  6'd41, 1'b0, 1'b1);   // last column closes row 41
      send_column(10'd2,    7'd0,   6'd0,  1'b0, 1'b0);   // after last: previous is empty
      send_column(10'd500,  7'd20,  6'd30, 1'b1, 1'b0);   // new plane drops the open row
      send_column(10'd501,  7'd0,   6'd63, 1'b0, 1'b1);   // mixed start columns, 64 closes
      send_column(10'd1023, 7'd0,   6'd63, 1'b1, 1'b1);   // one-column plane at the far edge
      send_column(10'd0,    7'd63,  6'd63, 1'b1, 1'b1);   // bottom row only
      send_column(10'd300,  TOP_EMPTY, 6'd63, 1'b1, 1'b1); // empty plane, no spans
      send_column(10'd341,  7'd85,  6'd21, 1'b0, 1'b0);   // alternating bit patterns
      send_column(10'd682,  7'd42,  6'd21, 1'b0, 1'b0);
      send_column(10'd683,  7'd21,  6'd42, 1'b0, 1'b0);
      send_column(10'd684,  7'd21,  6'd42, 1'b0, 1'b1);
   endtask

   task automatic test_random_planes();
      int target;
      target = columns_sent + 150;
      while (columns_sent < target) begin
         if ($urandom_range(0, 9) == 0) send_plane($urandom_range(17, 40));
         else send_plane($urandom_range(1, 16));
      end
   endtask

   // Sender holds off until the block and the result side are completely empty.
   task automatic test_pause_for_drain();
      send_plane(8);
      drain_expected();
      send_plane(6);
      drain_expected();
      send_plane(1);
      drain_expected();
      send_plane(10);
   endtask

   // No gaps and no stalls on either side.
   task automatic test_back_to_back();
      int target;
      no_idle = 1'b1;
      target  = columns_sent + 40;
      while (columns_sent < target) send_plane($urandom_range(1, 12));
      no_idle = 1'b0;
   endtask

   // Unstructured beats: any column, any top code, flags at random.
   task automatic test_noise();
      repeat (40) begin
         send_column(COL_W'($urandom_range(0, 1023)), TOP_W'($urandom_range(0, 127)),
                     ROW_W'($urandom_range(0, 63)), $urandom_range(0, 7) == 0,
                     $urandom_range(0, 7) == 0);
      end
   endtask

   // Result side: compare each beat with the oldest prediction, then stall at random.
   initial begin : span_checker
      span_beat_type want;
      int            hold;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            spans_checked++;
            if (expected_spans.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected span beat: expected none, got row %0d start %0d end %0d",
                        $time, rsp_span_row, rsp_span_start, rsp_span_end);
            end else begin
               want = expected_spans.pop_front();
               if (rsp_span_row !== want.span.row) begin
                  mismatch_count++;
                  $display("%0t: span_row: expected %0d, got %0d",
                           $time, want.span.row, rsp_span_row);
               end
               if (rsp_span_start !== want.span.start) begin
                  mismatch_count++;
                  $display("%0t: span_start: expected %0d, got %0d",
                           $time, want.span.start, rsp_span_start);
               end
               if (rsp_span_end !== want.span.stop) begin
                  mismatch_count++;
                  $display("%0t: span_end: expected %0d, got %0d",
                           $time, want.span.stop, rsp_span_end);
               end
               if (rsp_span_final !== want.closes_column) begin
                  mismatch_count++;
                  $display("%0t: span_final: expected %0b, got %0b",
                           $time, want.closes_column, rsp_span_final);
               end
            end
            hold = draw_wait();
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_column_x     = '0;
      req_top_row      = '0;
      req_bottom_row   = '0;
      req_first_column = 1'b0;
      req_last_column  = 1'b0;
      rsp_stall        = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_planes();
      test_pause_for_drain();
      test_back_to_back();
      test_noise();

      // let the last beats out, then watch for anything extra
      drain_expected();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d column beats: directed edges, plane walks, drain pauses,",
               columns_sent);
      $display("back-to-back planes and unstructured beats; %0d span beats checked, %0d mismatches.",
               spans_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
